@@ sv/cpw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cpw_pkg;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SET  = 2'd1,
		CMD_SLOT = 2'd2
	} cmd_t;

	localparam logic [1:0]  REG_SHOW_SLOTS = 2'd0;
	localparam logic [1:0]  REG_SET_SLOTS  = 2'd1;

	localparam logic [15:0] SHOW_SLOTS_RST = 16'd30000;
	localparam logic [15:0] SET_SLOTS_RST  = 16'd5000;

	localparam logic [5:0]  SEC_MAX    = 6'd60;
	localparam logic [6:0]  MIN_MAX    = 7'd60;
	localparam logic [3:0]  HOUR_MAX   = 4'd12;
	localparam logic [3:0]  PWM_LAST   = 4'd15;
	localparam logic [2:0]  MIN_STEP   = 3'd5;
	localparam logic [1:0]  TILT_COUNT = 2'd2;
	localparam logic [3:0]  LED_LAST   = 4'd12;

	typedef struct packed {
		cmd_t       cmd;
		logic       pad;
		logic       tilt;
	} item_t;

	typedef struct packed {
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [3:0]  hour;
		logic [1:0]  tilt;
		logic        setting;
		logic [16:0] slots;
		logic [3:0]  phase;
		logic [3:0]  min_led;
	} wstate_t;

	typedef struct packed {
		logic [3:0] pin_dir;
		logic [3:0] pin_high;
		logic [3:0] led_index;
		logic       wake;
		logic       display_active;
		logic       in_set_mode;
		logic [3:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} result_t;

	function automatic logic [3:0] led_dir_f(input logic [3:0] led);
		logic [3:0] d;
		case (led)
			4'd1:    d = 4'hC;
			4'd2:    d = 4'hA;
			4'd3:    d = 4'h3;
			4'd4:    d = 4'h6;
			4'd5:    d = 4'hC;
			4'd6:    d = 4'hA;
			4'd7:    d = 4'h5;
			4'd8:    d = 4'h5;
			4'd9:    d = 4'h9;
			4'd10:   d = 4'h9;
			4'd11:   d = 4'h3;
			4'd12:   d = 4'h6;
			default: d = 4'h0;
		endcase
		return d;
	endfunction

	function automatic logic [3:0] led_high_f(input logic [3:0] led);
		logic [3:0] h;
		case (led)
			4'd1:    h = 4'h4;
			4'd2:    h = 4'h2;
			4'd3:    h = 4'h2;
			4'd4:    h = 4'h4;
			4'd5:    h = 4'h8;
			4'd6:    h = 4'h8;
			4'd7:    h = 4'h4;
			4'd8:    h = 4'h1;
			4'd9:    h = 4'h8;
			4'd10:   h = 4'h1;
			4'd11:   h = 4'h1;
			4'd12:   h = 4'h2;
			default: h = 4'h0;
		endcase
		return h;
	endfunction

	// minute / 5 as (minute * 13) >> 6, exact for any 6-bit value
	function automatic logic [3:0] minute_led_f(input logic [5:0] min);
		logic [9:0] prod;
		logic [3:0] q;
		prod = 10'(min) * 10'd13;
		q = prod[9:6];
		if (q == 4'd0 || q > LED_LAST) begin
			q = LED_LAST;
		end
		return q;
	endfunction

endpackage

`default_nettype wire

@@ sv/charlieplexed_watch_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// twelve-hour watch with a four-pin charlieplexed led display
// input channel (in_valid / in_stall): one beat per command, cmd 0 is a
//   second tick, 1 a set step, 2 a display slot; set_pad_low and tilt_low
//   are sampled with the beat
// output channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order: the pins and led for the slot, wake, session and set
//   mode flags and the time after the command
// config channel (cfg_valid / cfg_ready): index 0 show_slots, index 1
//   set_slots; other indexes are dropped; cfg_ready is always high and
//   writes belong only between items
// path: a beat passes the input register and then the result register;
//   throughput one beat per cycle while out_stall is low, set by the single update of
//   the time and session counters between those two registers
// a stall on the output holds the result; the input register still takes
//   one more beat and then in_stall follows out_stall
// reset: time 12:01 second 1, no session, set mode off, registers at
//   30000 and 5000; both channels empty
module charlieplexed_watch_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic        set_pad_low,
	input  wire logic        tilt_low,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       pin_dir,
	output logic [3:0]       pin_high,
	output logic [3:0]       led_index,
	output logic             wake,
	output logic             display_active,
	output logic             in_set_mode,
	output logic [3:0]       hours,
	output logic [5:0]       minutes,
	output logic [5:0]       seconds,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import cpw_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	result_t     res_q;
	wstate_t     state_q;
	wstate_t     state_nxt;
	result_t     res_nxt;
	logic [15:0] show_slots_q;
	logic [15:0] set_slots_q;
	logic        adv;

	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.cmd  <= cmd_t'(cmd);
			item_s1.pad  <= set_pad_low;
			item_s1.tilt <= tilt_low;
		end
	end

	cpw_step u_step (
		.item       (item_s1),
		.cur        (state_q),
		.show_slots (show_slots_q),
		.set_slots  (set_slots_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.sec     <= 6'd1;
			state_q.min     <= 6'd1;
			state_q.hour    <= HOUR_MAX;
			state_q.tilt    <= 2'd0;
			state_q.setting <= 1'b0;
			state_q.slots   <= 17'd0;
			state_q.phase   <= 4'd0;
			state_q.min_led <= LED_LAST;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_slots_q <= SHOW_SLOTS_RST;
			set_slots_q  <= SET_SLOTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SHOW_SLOTS: show_slots_q <= cfg_data;
				REG_SET_SLOTS:  set_slots_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign pin_dir        = res_q.pin_dir;
	assign pin_high       = res_q.pin_high;
	assign led_index      = res_q.led_index;
	assign wake           = res_q.wake;
	assign display_active = res_q.display_active;
	assign in_set_mode    = res_q.in_set_mode;
	assign hours          = res_q.hours;
	assign minutes        = res_q.minutes;
	assign seconds        = res_q.seconds;

	a_hour_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hour != 4'd0 && state_q.hour <= HOUR_MAX)
		else $error("hour out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.min != 6'd0 && state_q.min <= SEC_MAX &&
		state_q.sec != 6'd0 && state_q.sec <= SEC_MAX)
		else $error("minute or second out of range");

	a_tilt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.tilt < TILT_COUNT)
		else $error("tilt filter passed its limit");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

endmodule

`default_nettype wire

@@ sv/cpw_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cpw_step (
	input  wire cpw_pkg::item_t   item,
	input  wire cpw_pkg::wstate_t cur,
	input  wire logic [15:0]      show_slots,
	input  wire logic [15:0]      set_slots,
	output cpw_pkg::wstate_t      nxt,
	output cpw_pkg::result_t      res
);
	import cpw_pkg::*;

	wstate_t    s;
	logic [3:0] led;
	logic       wake;
	logic [1:0] tilt_inc;

	function automatic wstate_t adv_min(input wstate_t st, input logic [2:0] by);
		logic [6:0] sum;
		sum = {1'b0, st.min} + 7'(by);
		if (sum > MIN_MAX) begin
			st.min = 6'd1;
			st.hour = (st.hour >= HOUR_MAX) ? 4'd1 : st.hour + 4'd1;
		end else begin
			st.min = sum[5:0];
		end
		return st;
	endfunction

	function automatic wstate_t start(input wstate_t st, input logic [15:0] len);
		st.min_led = minute_led_f(st.min);
		st.phase = 4'd0;
		st.slots = {1'b0, len} + 17'd1;
		return st;
	endfunction

	always_comb begin
		s = cur;
		led = 4'd0;
		wake = 1'b0;
		tilt_inc = cur.tilt + 2'd1;
		if (!item.pad) begin
			s.setting = 1'b0;
		end
		unique case (item.cmd)
			CMD_TICK: begin
				if (!s.setting) begin
					if (s.sec >= SEC_MAX) begin
						s.sec = 6'd1;
						s = adv_min(s, 3'd1);
					end else begin
						s.sec = s.sec + 6'd1;
					end
					if (item.pad) begin
						s.min = 6'd1;
						s = adv_min(s, MIN_STEP);
						s.setting = 1'b1;
						s = start(s, set_slots);
					end else if (item.tilt) begin
						if (tilt_inc == TILT_COUNT) begin
							s.tilt = 2'd0;
							wake = 1'b1;
							s = start(s, show_slots);
						end else begin
							s.tilt = tilt_inc;
						end
					end
				end
			end
			CMD_SET: begin
				if (s.setting) begin
					s = adv_min(s, MIN_STEP);
					s = start(s, set_slots);
				end
			end
			CMD_SLOT: begin
				if (s.slots != 17'd0) begin
					if (s.phase == PWM_LAST) begin
						led = s.min_led;
						s.phase = 4'd1;
					end else begin
						led = s.hour;
						s.phase = s.phase + 4'd1;
					end
					s.slots = s.slots - 17'd1;
					if (led > LED_LAST) begin
						led = 4'd0;
					end
				end
			end
			default: ;
		endcase
	end

	assign nxt = s;

	always_comb begin
		res.pin_dir        = led_dir_f(led);
		res.pin_high       = led_high_f(led);
		res.led_index      = led;
		res.wake           = wake;
		res.display_active = (s.slots != 17'd0);
		res.in_set_mode    = s.setting;
		res.hours          = s.hour;
		res.minutes        = s.min;
		res.seconds        = s.sec;
	end

endmodule

`default_nettype wire
